[sv/ppu_pkg.sv]
// Package for the packed pattern unpacker: payload structs, parse phases,
// result kinds and the phase sequencing function. No dependencies.
package ppu_pkg;

  // Rows in one pattern; the row counter wraps after the last row
  localparam int unsigned ROWS_PER_PATTERN = 64;
  localparam int unsigned ROW_W = (ROWS_PER_PATTERN > 1) ? $clog2(ROWS_PER_PATTERN) : 1;

  // Control byte flag bits
  localparam int unsigned BIT_NOTE = 5;
  localparam int unsigned BIT_VOL  = 6;
  localparam int unsigned BIT_EFF  = 7;

  // Channel count after reset
  localparam logic [5:0] CHAN_COUNT_RESET = 6'd32;

  typedef enum logic [2:0] {
    PH_CTRL  = 3'd0,
    PH_NOTE  = 3'd1,
    PH_INST  = 3'd2,
    PH_VOL   = 3'd3,
    PH_EKIND = 3'd4,
    PH_EVAL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_t;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_req_t;

  // Result request
  typedef struct packed {
    kind_t      kind;
    logic [5:0] row_index;
    logic [4:0] channel_index;
    logic       has_note;
    logic [7:0] note_byte;
    logic [7:0] instrument_number;
    logic       vol_present;
    logic [7:0] volume_byte;
    logic       fx_present;
    logic [7:0] effect_kind;
    logic [7:0] effect_value;
  } out_req_t;

  // Classified record passed from the parser to the output stage
  typedef struct packed {
    kind_t      kind;
    logic [5:0] row;
    logic [7:0] ctrl;
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] vol;
    logic [7:0] ekind;
    logic [7:0] evalue;
  } rec_t;

  // Phase after the given one, PH_CTRL when the cell is complete
  function automatic phase_t next_phase(input phase_t from, input logic [7:0] ctrl);
    phase_t nx;
    nx = PH_CTRL;
    if (from == PH_CTRL && ctrl[BIT_NOTE]) begin
      nx = PH_NOTE;
    end else if (from == PH_NOTE) begin
      nx = PH_INST;
    end else if ((from == PH_CTRL || from == PH_INST) && ctrl[BIT_VOL]) begin
      nx = PH_VOL;
    end else if ((from == PH_CTRL || from == PH_INST || from == PH_VOL) && ctrl[BIT_EFF]) begin
      nx = PH_EKIND;
    end else if (from == PH_EKIND) begin
      nx = PH_EVAL;
    end
    return nx;
  endfunction

  // Low six bits of the row counter, zero extended when narrower
  function automatic logic [5:0] row_low6(input logic [ROW_W-1:0] row);
    logic [ROW_W+5:0] wide;
    wide = {6'd0, row};
    return wide[5:0];
  endfunction

endpackage

[sv/ppu_front.sv]
// Front end of the pattern unpacker: accepts stream bytes, tracks the parse
// phase, row and held cell bytes, and pushes result records. Uses ppu_pkg.
module ppu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  ppu_pkg::in_req_t in_req,
  input  logic            cfg_we,
  input  logic [5:0]      cfg_data,
  output logic            push,
  output ppu_pkg::rec_t   push_rec
);

  ppu_pkg::phase_t              phase_r, phase_nxt;
  logic [7:0]                   ctrl_r, ctrl_nxt;
  logic [ppu_pkg::ROW_W-1:0]    row_r, row_nxt;
  logic [7:0]                   note_r, note_nxt;
  logic [7:0]                   inst_r, inst_nxt;
  logic [7:0]                   vol_r, vol_nxt;
  logic [7:0]                   ekind_r, ekind_nxt;
  logic [5:0]                   chan_count_r;

  logic [7:0]      byte_in;
  logic            zero_chan;
  logic            last_row;
  logic            cell_done;
  ppu_pkg::phase_t after;

  assign byte_in   = in_req.data_byte;
  assign zero_chan = (chan_count_r == 6'd0);
  assign last_row  = (row_r == ppu_pkg::ROW_W'(ppu_pkg::ROWS_PER_PATTERN - 1));

  // Next state of the parser
  always_comb begin
    phase_nxt = phase_r;
    ctrl_nxt  = ctrl_r;
    row_nxt   = row_r;
    note_nxt  = note_r;
    inst_nxt  = inst_r;
    vol_nxt   = vol_r;
    ekind_nxt = ekind_r;
    after     = ppu_pkg::PH_CTRL;
    if (acc) begin
      if (zero_chan || (in_req.end_of_stream &&
                        !(phase_r == ppu_pkg::PH_CTRL && row_r == '0))) begin
        // restart after either error
        phase_nxt = ppu_pkg::PH_CTRL;
        ctrl_nxt  = 8'd0;
        row_nxt   = '0;
      end else if (!in_req.end_of_stream) begin
        case (phase_r)
          ppu_pkg::PH_CTRL: begin
            if (byte_in == 8'd0) begin
              row_nxt = last_row ? '0 : row_r + 1'b1;
            end else begin
              ctrl_nxt = byte_in;
            end
          end
          ppu_pkg::PH_NOTE:  note_nxt  = byte_in;
          ppu_pkg::PH_INST:  inst_nxt  = byte_in;
          ppu_pkg::PH_VOL:   vol_nxt   = byte_in;
          ppu_pkg::PH_EKIND: ekind_nxt = byte_in;
          default: ;
        endcase
        after = ppu_pkg::next_phase(phase_r, ctrl_nxt);
        if (!(phase_r == ppu_pkg::PH_CTRL && byte_in == 8'd0)) begin
          phase_nxt = after;
        end
      end
    end
  end

  // Result record for the accepted byte
  always_comb begin
    push            = 1'b0;
    cell_done       = 1'b0;
    push_rec.kind   = ppu_pkg::KIND_CELL;
    push_rec.row    = ppu_pkg::row_low6(row_r);
    push_rec.ctrl   = ctrl_nxt;
    push_rec.note   = note_nxt;
    push_rec.inst   = inst_nxt;
    push_rec.vol    = vol_nxt;
    push_rec.ekind  = ekind_nxt;
    push_rec.evalue = (phase_r == ppu_pkg::PH_EVAL) ? byte_in : 8'd0;
    if (acc) begin
      if (zero_chan) begin
        push          = 1'b1;
        push_rec.kind = ppu_pkg::KIND_ZERO;
      end else if (in_req.end_of_stream) begin
        push          = !(phase_r == ppu_pkg::PH_CTRL && row_r == '0);
        push_rec.kind = ppu_pkg::KIND_TRUNC;
      end else if (phase_r == ppu_pkg::PH_CTRL && byte_in == 8'd0) begin
        push          = last_row;
        push_rec.kind = ppu_pkg::KIND_DONE;
      end else begin
        cell_done = (after == ppu_pkg::PH_CTRL);
        push      = cell_done && ({1'b0, ctrl_nxt[4:0]} < chan_count_r);
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= ppu_pkg::PH_CTRL;
      ctrl_r    <= 8'd0;
      row_r     <= '0;
      note_r    <= 8'd0;
      inst_r    <= 8'd0;
      vol_r     <= 8'd0;
      ekind_r   <= 8'd0;
    end else begin
      phase_r   <= phase_nxt;
      ctrl_r    <= ctrl_nxt;
      row_r     <= row_nxt;
      note_r    <= note_nxt;
      inst_r    <= inst_nxt;
      vol_r     <= vol_nxt;
      ekind_r   <= ekind_nxt;
    end
  end

  // Channel count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= ppu_pkg::CHAN_COUNT_RESET;
    end else if (cfg_we) begin
      chan_count_r <= cfg_data;
    end
  end

endmodule

[sv/ppu_queue.sv]
// Two-entry record queue between the parser and the output stage.
// Uses ppu_pkg for the record type.
module ppu_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppu_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output ppu_pkg::rec_t head
);

  ppu_pkg::rec_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[sv/ppu_back.sv]
// Output stage of the pattern unpacker: formats queued records into result
// requests and holds them in the output register. Uses ppu_pkg.
module ppu_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  ppu_pkg::rec_t    q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output ppu_pkg::out_req_t out_data
);

  logic              out_valid_r, out_valid_nxt;
  ppu_pkg::out_req_t out_data_r, fmt;
  logic              is_cell;

  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Expand a record; absent parts and non-cell results read as zero
  always_comb begin
    is_cell                = (q_head.kind == ppu_pkg::KIND_CELL);
    fmt                    = '0;
    fmt.kind               = q_head.kind;
    if (is_cell) begin
      fmt.row_index     = q_head.row;
      fmt.channel_index = q_head.ctrl[4:0];
      if (q_head.ctrl[ppu_pkg::BIT_NOTE]) begin
        fmt.has_note          = 1'b1;
        fmt.note_byte         = q_head.note;
        fmt.instrument_number = q_head.inst;
      end
      if (q_head.ctrl[ppu_pkg::BIT_VOL]) begin
        fmt.vol_present = 1'b1;
        fmt.volume_byte = q_head.vol;
      end
      if (q_head.ctrl[ppu_pkg::BIT_EFF]) begin
        fmt.fx_present   = 1'b1;
        fmt.effect_kind  = q_head.ekind;
        fmt.effect_value = q_head.evalue;
      end
    end
  end

  // Output valid: load on pop, clear once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= fmt;
    end
  end

endmodule

[sv/packed_pattern_unpacker.sv]
// Packed pattern unpacker top level: parser front end, record queue and
// output stage. Depends on ppu_pkg, ppu_front, ppu_queue and ppu_back.
//
// Usage:
//   in_*   : one stream byte (or end-of-stream mark) per request, valid/stall.
//   out_*  : cell writes, pattern done and error results, valid/stall.
//   cfg_*  : channel count write; cfg_ready is always high, write only idle.
// Throughput is one input byte per cycle while in_stall is low; each byte
// needs a single parse phase update in the front end. A byte that yields a
// result passes through the queue and then the output register before it
// shows on out_valid. Bytes that yield no result only update the parser.
// in_stall rises only when the two-entry queue is full, which happens when
// the receiver holds out_stall; the parser then waits while the output
// register and queue keep their contents. Reset (rst_n low, synchronous)
// empties the queue and output, sets the channel count to 32 and puts the
// parser at the start of a pattern (row 0, expecting a control byte).
module packed_pattern_unpacker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ppu_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ppu_pkg::out_req_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [5:0]        cfg_data
);

  logic          acc;
  logic          push;
  ppu_pkg::rec_t push_rec;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  ppu_pkg::rec_t q_head;

  assign in_stall  = q_full;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ppu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_req   (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .push     (push),
    .push_rec (push_rec)
  );

  ppu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ppu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
